FILE: rtl/rth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_pkg
// Shared widths, codes and stage types for the RGB to HSV byte converter.
// ----------------------------------------------------------------------------
package rth_pkg;

  // Pixel channel width.
  localparam int PIX_W = 8;
  // Hue offset n lies below 6*255, so it needs 11 bits.
  localparam int N_W = 11;
  // Hue divisor 6*delta is at most 1530.
  localparam int HDIV_W = 11;
  // Hue numerator 255*n is below 255*1530.
  localparam int HNUM_W = 19;
  // Saturation numerator 255*delta.
  localparam int SNUM_W = 16;
  // Both quotients are below 256: one divider stage per quotient bit.
  localparam int QUO_W = 8;
  // Sort, offset and scale stages in front of the divider stages.
  localparam int FRONT_STAGES = 3;
  localparam int NUM_STAGES = FRONT_STAGES + QUO_W;

  // Which channel holds the maximum; ties go to red, then green.
  typedef enum logic [2:0] {
    SEL_RED   = 3'b001,
    SEL_GREEN = 3'b010,
    SEL_BLUE  = 3'b100
  } max_sel_t;

  // Payload of one divider stage: both long divisions advance together.
  typedef struct packed {
    logic              gray;
    logic [PIX_W-1:0]  vmax;
    logic [HNUM_W-1:0] hrem;
    logic [HDIV_W-1:0] hdiv;
    logic [QUO_W-1:0]  hq;
    logic [SNUM_W-1:0] srem;
    logic [PIX_W-1:0]  sdiv;
    logic [QUO_W-1:0]  sq;
  } div_stage_t;

endpackage

FILE: rtl/rth_rgb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_rgb_if
// Ready/valid channel that carries one RGB pixel per transfer.
// ----------------------------------------------------------------------------
interface rth_rgb_if import rth_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/rth_hsv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_hsv_if
// Ready/valid channel that carries one HSV pixel per transfer.
// ----------------------------------------------------------------------------
interface rth_hsv_if import rth_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] hue;
  logic [PIX_W-1:0] saturation;
  logic [PIX_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

FILE: rtl/rgb_to_hsv_byte.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_byte
// Pipelined conversion of 8-bit RGB pixels to 8-bit HSV.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                          Handshake
//   in_rgb    sink       red, green, blue (8 bits each)   valid / ready
//   out_hsv   source     hue, saturation, brightness      valid / ready
//
// One pixel is taken per clock cycle while the output is not stalled, and
// each result passes in order through three front stages (sort, hue offset,
// scaling) followed by eight restoring divider stages, one quotient bit each.
// Reset clears every stage valid bit; the data registers are not reset.
// Each stage has its own ready, so a stalled output only holds the stages
// that are occupied, and bubbles further up keep filling.
// ----------------------------------------------------------------------------
module rgb_to_hsv_byte import rth_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rth_rgb_if.sink    in_rgb,
  rth_hsv_if.source  out_hsv
);

  // Stage valid bits and the ready chain. A stage may load when it is empty
  // or when the stage below it loads in the same cycle.
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES:0]   rdy;

  assign rdy[NUM_STAGES] = out_hsv.ready;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_rdy
    assign rdy[i] = ~vld_r[i] | rdy[i+1];
  end

  assign in_rgb.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_rgb.valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: find the largest and smallest channel and which channel is the
  // maximum. Ties go to red first, then to green.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] r0_r, g0_r, b0_r, max0_r, min0_r;
  max_sel_t         sel0_r;
  logic [PIX_W-1:0] max0_nxt, min0_nxt;
  max_sel_t         sel0_nxt;

  always_comb begin
    if (in_rgb.red >= in_rgb.green && in_rgb.red >= in_rgb.blue) begin
      sel0_nxt = SEL_RED;
      max0_nxt = in_rgb.red;
    end else if (in_rgb.green >= in_rgb.blue) begin
      sel0_nxt = SEL_GREEN;
      max0_nxt = in_rgb.green;
    end else begin
      sel0_nxt = SEL_BLUE;
      max0_nxt = in_rgb.blue;
    end
    min0_nxt = (in_rgb.red < in_rgb.green) ? in_rgb.red : in_rgb.green;
    if (in_rgb.blue < min0_nxt) begin
      min0_nxt = in_rgb.blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      r0_r   <= in_rgb.red;
      g0_r   <= in_rgb.green;
      b0_r   <= in_rgb.blue;
      max0_r <= max0_nxt;
      min0_r <= min0_nxt;
      sel0_r <= sel0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: delta and the hue offset n, measured in units of delta around
  // the hue circle. n stays below 6*delta whenever delta is nonzero.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] max1_r, delta1_r;
  logic [N_W-1:0]   n1_r;
  logic             gray1_r;
  logic [PIX_W-1:0] delta1_nxt;
  logic [N_W-1:0]   d_ext, r_ext, g_ext, b_ext, n1_nxt;

  always_comb begin
    delta1_nxt = max0_r - min0_r;
    d_ext = {{(N_W-PIX_W){1'b0}}, delta1_nxt};
    r_ext = {{(N_W-PIX_W){1'b0}}, r0_r};
    g_ext = {{(N_W-PIX_W){1'b0}}, g0_r};
    b_ext = {{(N_W-PIX_W){1'b0}}, b0_r};
    case (sel0_r)
      SEL_RED: begin
        // Wrap a negative green minus blue around the full circle.
        if (g0_r >= b0_r) begin
          n1_nxt = g_ext - b_ext;
        end else begin
          n1_nxt = (d_ext << 2) + (d_ext << 1) - (b_ext - g_ext);
        end
      end
      SEL_GREEN: n1_nxt = b_ext + (d_ext << 1) - r_ext;
      SEL_BLUE:  n1_nxt = r_ext + (d_ext << 2) - g_ext;
      default:   n1_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      max1_r   <= max0_r;
      delta1_r <= delta1_nxt;
      n1_r     <= n1_nxt;
      gray1_r  <= (delta1_nxt == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale the numerators by 255 with shift and subtract, and form
  // the hue divisor 6*delta. This loads the first divider stage.
  // --------------------------------------------------------------------------
  div_stage_t       dstg_r [0:QUO_W];
  div_stage_t       dstg0_nxt;
  logic [HDIV_W-1:0] dlt_ext;

  always_comb begin
    dlt_ext             = {{(HDIV_W-PIX_W){1'b0}}, delta1_r};
    dstg0_nxt.gray      = gray1_r;
    dstg0_nxt.vmax      = max1_r;
    dstg0_nxt.hrem      = {n1_r, 8'b0} - {8'b0, n1_r};
    dstg0_nxt.hdiv      = (dlt_ext << 2) + (dlt_ext << 1);
    dstg0_nxt.hq        = '0;
    dstg0_nxt.srem      = {delta1_r, 8'b0} - {8'b0, delta1_r};
    dstg0_nxt.sdiv      = max1_r;
    dstg0_nxt.sq        = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dstg_r[0] <= dstg0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages: restoring long division, most significant quotient bit
  // first. Both quotients are known to fit in eight bits, so the first trial
  // subtracts the divisor shifted left by seven.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int Bit = QUO_W - 1 - k;
    div_stage_t        step_nxt;
    logic [HNUM_W-1:0] htrial;
    logic [SNUM_W-1:0] strial;

    always_comb begin
      step_nxt = dstg_r[k];
      htrial   = {{(HNUM_W-HDIV_W){1'b0}}, dstg_r[k].hdiv} << Bit;
      strial   = {{(SNUM_W-PIX_W){1'b0}}, dstg_r[k].sdiv} << Bit;
      if (dstg_r[k].hrem >= htrial) begin
        step_nxt.hrem    = dstg_r[k].hrem - htrial;
        step_nxt.hq[Bit] = 1'b1;
      end
      if (dstg_r[k].srem >= strial) begin
        step_nxt.srem    = dstg_r[k].srem - strial;
        step_nxt.sq[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[FRONT_STAGES+k]) begin
        dstg_r[k+1] <= step_nxt;
      end
    end
  end

  // A gray pixel divides by zero in the hue path (and in the saturation path
  // for black); its hue and saturation are forced to zero here.
  assign out_hsv.valid      = vld_r[NUM_STAGES-1];
  assign out_hsv.hue        = dstg_r[QUO_W].gray ? '0 : dstg_r[QUO_W].hq;
  assign out_hsv.saturation = dstg_r[QUO_W].gray ? '0 : dstg_r[QUO_W].sq;
  assign out_hsv.brightness = dstg_r[QUO_W].vmax;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // An accepted pixel always lands in the first stage.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_rgb.valid && in_rgb.ready) |=> vld_r[0])
    else $error("accepted pixel did not enter the first stage");

  // A blocked first stage keeps its contents.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && !rdy[0]) |=> (vld_r[0] && $stable(max0_r) && $stable(min0_r)))
    else $error("stalled first stage changed its contents");

  // After the last divider stage both remainders are below their divisors.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hsv.valid && !dstg_r[QUO_W].gray) |->
      (dstg_r[QUO_W].hrem < {{(HNUM_W-HDIV_W){1'b0}}, dstg_r[QUO_W].hdiv} &&
       dstg_r[QUO_W].srem < {{(SNUM_W-PIX_W){1'b0}}, dstg_r[QUO_W].sdiv}))
    else $error("divider finished with a remainder not below the divisor");

  // Black has neither hue nor saturation.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hsv.valid && out_hsv.brightness == '0) |->
      (out_hsv.hue == '0 && out_hsv.saturation == '0))
    else $error("black pixel produced nonzero hue or saturation");

endmodule
